// File: rtl/oca_pkg.sv
// Package for the overflow-checked ALU: widths, operation codes and the
// payload that travels down the pipeline. No dependencies.
package oca_pkg;

    localparam int DATA_WIDTH  = 64;
    localparam int SHIFT_W     = $clog2(DATA_WIDTH);
    localparam int HALF_W      = DATA_WIDTH / 2;
    localparam int DEPTH       = DATA_WIDTH + 2;
    localparam int MUL_MERGE   = 3;
    localparam int OP_W        = 4;
    localparam int IN_TDATA_W  = ((OP_W + 2 * DATA_WIDTH + 7) / 8) * 8;
    localparam int OUT_TDATA_W = ((DATA_WIDTH + 1 + 7) / 8) * 8;

    typedef logic [DATA_WIDTH-1:0] word_t;

    localparam word_t WMASK     = '1;
    localparam word_t WSIGN     = {1'b1, {(DATA_WIDTH-1){1'b0}}};
    localparam word_t SMAX      = ~WSIGN;
    localparam word_t WIDTH_VAL = word_t'(DATA_WIDTH);

    typedef enum logic [OP_W-1:0] {
        OP_ADD  = 4'd0,
        OP_SUB  = 4'd1,
        OP_MUL  = 4'd2,
        OP_DIV  = 4'd3,
        OP_REM  = 4'd4,
        OP_SHL  = 4'd5,
        OP_SHR  = 4'd6,
        OP_SADD = 4'd7,
        OP_SSUB = 4'd8,
        OP_SMUL = 4'd9,
        OP_SDIV = 4'd10,
        OP_SREM = 4'd11,
        OP_NEG  = 4'd12,
        OP_SSHL = 4'd13,
        OP_SSHR = 4'd14
    } op_t;

    typedef struct packed {
        op_t   op;
        logic  neg_q;
        logic  neg_r;
        logic  err;
        word_t res;
    } pl_t;

    function automatic word_t apply_sign(word_t mag, logic negative);
        return negative ? word_t'(word_t'(0) - mag) : mag;
    endfunction

endpackage

// File: rtl/oca_decode.sv
// First pipeline stage of the ALU: decodes the operation, finishes the
// add, subtract, shift and negate operations and prepares operand magnitudes. Uses oca_pkg.
module oca_decode (
    input  logic          aclk,
    input  logic          en,
    input  oca_pkg::op_t  op_i,
    input  oca_pkg::word_t a_i,
    input  oca_pkg::word_t b_i,
    output oca_pkg::pl_t  pl_o,
    output oca_pkg::word_t ma_o,
    output oca_pkg::word_t mb_o
);
    import oca_pkg::*;

    pl_t   pl_reg, pl_next;
    word_t ma_reg, ma_next;
    word_t mb_reg, mb_next;

    logic                sa, sb, b_big, sgn;
    logic [SHIFT_W-1:0]  shamt;
    logic [DATA_WIDTH:0] sum, diff;
    word_t               neg_a, neg_b, ua, ub;

    always_comb begin
        sa     = a_i[DATA_WIDTH-1];
        sb     = b_i[DATA_WIDTH-1];
        shamt  = b_i[SHIFT_W-1:0];
        b_big  = (b_i >= WIDTH_VAL);
        sum    = {1'b0, a_i} + {1'b0, b_i};
        diff   = {1'b0, a_i} - {1'b0, b_i};
        neg_a  = word_t'(0) - a_i;
        neg_b  = word_t'(0) - b_i;
        ua     = sa ? neg_a : a_i;
        ub     = sb ? neg_b : b_i;
        sgn    = (op_i == OP_SMUL) || (op_i == OP_SDIV) || (op_i == OP_SREM);
        ma_next = sgn ? ua : a_i;
        mb_next = sgn ? ub : b_i;

        pl_next.op    = op_i;
        pl_next.neg_q = sgn && (sa ^ sb);
        pl_next.neg_r = sgn && sa;
        pl_next.err   = 1'b0;
        pl_next.res   = '0;
        case (op_i)
            OP_ADD: begin
                pl_next.err = sum[DATA_WIDTH];
                pl_next.res = sum[DATA_WIDTH-1:0];
            end
            OP_SUB: begin
                pl_next.err = diff[DATA_WIDTH];
                pl_next.res = diff[DATA_WIDTH-1:0];
            end
            OP_MUL, OP_SMUL: begin
                pl_next.err = 1'b0;
            end
            OP_DIV, OP_REM: begin
                pl_next.err = (b_i == '0);
            end
            OP_SDIV, OP_SREM: begin
                pl_next.err = (b_i == '0) || ((a_i == WSIGN) && (b_i == WMASK));
            end
            OP_SHL: begin
                pl_next.err = b_big || (a_i > (WMASK >> shamt));
                pl_next.res = a_i << shamt;
            end
            OP_SHR: begin
                pl_next.err = b_big;
                pl_next.res = a_i >> shamt;
            end
            OP_SADD: begin
                pl_next.err = (a_i[DATA_WIDTH-1] ^ sum[DATA_WIDTH-1])
                            & (b_i[DATA_WIDTH-1] ^ sum[DATA_WIDTH-1]);
                pl_next.res = sum[DATA_WIDTH-1:0];
            end
            OP_SSUB: begin
                pl_next.err = (a_i[DATA_WIDTH-1] ^ b_i[DATA_WIDTH-1])
                            & (a_i[DATA_WIDTH-1] ^ diff[DATA_WIDTH-1]);
                pl_next.res = diff[DATA_WIDTH-1:0];
            end
            OP_NEG: begin
                pl_next.err = (a_i == WSIGN);
                pl_next.res = neg_a;
            end
            OP_SSHL: begin
                pl_next.err = sa || b_big || (a_i > (SMAX >> shamt));
                pl_next.res = a_i << shamt;
            end
            OP_SSHR: begin
                pl_next.err = sa || b_big;
                pl_next.res = a_i >> shamt;
            end
            default: begin
                pl_next.err = 1'b1;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            pl_reg <= pl_next;
            ma_reg <= ma_next;
            mb_reg <= mb_next;
        end
    end

    assign pl_o = pl_reg;
    assign ma_o = ma_reg;
    assign mb_o = mb_reg;

endmodule

// File: rtl/oca_mul.sv
// Two-stage multiplier of the ALU: four half-width partial products, then
// their sum, with the overflow check on the full product. Uses oca_pkg.
module oca_mul (
    input  logic           aclk,
    input  logic           en1,
    input  logic           en2,
    input  oca_pkg::word_t ma_i,
    input  oca_pkg::word_t mb_i,
    input  logic           sgn_i,
    input  logic           neg_i,
    output oca_pkg::word_t res_o,
    output logic           err_o
);
    import oca_pkg::*;

    logic [DATA_WIDTH-1:0]   pll_reg, plh_reg, phl_reg, phh_reg;
    logic                    sgn1_reg, neg1_reg, sgn2_reg, neg2_reg;
    logic [2*DATA_WIDTH-1:0] prod_reg, prod_next;
    word_t                   lo, hi, lim;

    always_ff @(posedge aclk) begin
        if (en1) begin
            pll_reg  <= ma_i[HALF_W-1:0] * mb_i[HALF_W-1:0];
            plh_reg  <= ma_i[HALF_W-1:0] * mb_i[DATA_WIDTH-1:HALF_W];
            phl_reg  <= ma_i[DATA_WIDTH-1:HALF_W] * mb_i[HALF_W-1:0];
            phh_reg  <= ma_i[DATA_WIDTH-1:HALF_W] * mb_i[DATA_WIDTH-1:HALF_W];
            sgn1_reg <= sgn_i;
            neg1_reg <= neg_i;
        end
        if (en2) begin
            prod_reg <= prod_next;
            sgn2_reg <= sgn1_reg;
            neg2_reg <= neg1_reg;
        end
    end

    always_comb begin
        prod_next = {{DATA_WIDTH{1'b0}}, pll_reg}
                  + ({{DATA_WIDTH{1'b0}}, plh_reg} << HALF_W)
                  + ({{DATA_WIDTH{1'b0}}, phl_reg} << HALF_W)
                  + {phh_reg, {DATA_WIDTH{1'b0}}};
        lo    = prod_reg[DATA_WIDTH-1:0];
        hi    = prod_reg[2*DATA_WIDTH-1:DATA_WIDTH];
        lim   = neg2_reg ? WSIGN : SMAX;
        err_o = (hi != '0) || (sgn2_reg && (lo > lim));
        res_o = apply_sign(lo, neg2_reg);
    end

endmodule

// File: rtl/oca_div_step.sv
// One restoring division stage of the ALU: produces one quotient bit and
// carries the payload of the word along. Uses oca_pkg.
module oca_div_step (
    input  logic           aclk,
    input  logic           en,
    input  oca_pkg::word_t rem_i,
    input  oca_pkg::word_t quo_i,
    input  oca_pkg::word_t den_i,
    input  oca_pkg::pl_t   pl_i,
    output oca_pkg::word_t rem_o,
    output oca_pkg::word_t quo_o,
    output oca_pkg::word_t den_o,
    output oca_pkg::pl_t   pl_o
);
    import oca_pkg::*;

    word_t               rem_reg, rem_next, quo_reg, quo_next, den_reg;
    pl_t                 pl_reg;
    logic [DATA_WIDTH:0] wide, trial;
    logic                fits;

    always_comb begin
        wide     = {rem_i, quo_i[DATA_WIDTH-1]};
        trial    = wide - {1'b0, den_i};
        fits     = (wide >= {1'b0, den_i});
        rem_next = fits ? trial[DATA_WIDTH-1:0] : wide[DATA_WIDTH-1:0];
        quo_next = {quo_i[DATA_WIDTH-2:0], fits};
    end

    always_ff @(posedge aclk) begin
        if (en) begin
            rem_reg <= rem_next;
            quo_reg <= quo_next;
            den_reg <= den_i;
            pl_reg  <= pl_i;
        end
    end

    assign rem_o = rem_reg;
    assign quo_o = quo_reg;
    assign den_o = den_reg;
    assign pl_o  = pl_reg;

endmodule

// File: rtl/overflow_checked_alu.sv
// Top level of the overflow-checked ALU; builds on oca_pkg, oca_decode,
// oca_mul and oca_div_step.
// The block accepts one word per cycle unless a stalled output has filled
// the pipeline. Each word passes through one decode stage, one stage per
// quotient bit of the restoring divider, and the output register. The
// multiplier runs beside the first divider stages and its result joins
// the payload at stage MUL_MERGE. Each stage holds only while the stages
// after it are full, so empty stages close up behind a stalled output.
module overflow_checked_alu (
    input  logic                              aclk,
    input  logic                              aresetn,
    input  logic                              s_tvalid,
    output logic                              s_tready,
    // operation [3:0], operand_a [67:4], operand_b [131:68]
    input  logic [oca_pkg::IN_TDATA_W-1:0]    s_tdata,
    output logic                              m_tvalid,
    input  logic                              m_tready,
    // result_value [63:0], overflow_flag [64]
    output logic [oca_pkg::OUT_TDATA_W-1:0]   m_tdata
);
    import oca_pkg::*;

    logic [DEPTH-1:0] valid_reg, en;
    pl_t              pl    [0:DATA_WIDTH];
    pl_t              pl_in [1:DATA_WIDTH];
    word_t            rem   [0:DATA_WIDTH];
    word_t            quo   [0:DATA_WIDTH];
    word_t            den   [0:DATA_WIDTH];
    word_t            mul_res, val, data_reg, data_next;
    logic             mul_err, flag_reg, flag_next;
    op_t              op_in;

    assign op_in = op_t'(s_tdata[OP_W-1:0]);

    always_comb begin
        en[DEPTH-1] = !valid_reg[DEPTH-1] || m_tready;
        for (int k = DEPTH - 2; k >= 0; k--) begin
            en[k] = !valid_reg[k] || en[k+1];
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= '0;
        end else begin
            if (en[0]) begin
                valid_reg[0] <= s_tvalid;
            end
            for (int k = 1; k < DEPTH; k++) begin
                if (en[k]) begin
                    valid_reg[k] <= valid_reg[k-1];
                end
            end
        end
    end

    oca_decode u_decode (
        .aclk (aclk),
        .en   (en[0]),
        .op_i (op_in),
        .a_i  (s_tdata[OP_W+DATA_WIDTH-1:OP_W]),
        .b_i  (s_tdata[OP_W+2*DATA_WIDTH-1:OP_W+DATA_WIDTH]),
        .pl_o (pl[0]),
        .ma_o (quo[0]),
        .mb_o (den[0])
    );

    assign rem[0] = '0;

    oca_mul u_mul (
        .aclk  (aclk),
        .en1   (en[1]),
        .en2   (en[2]),
        .ma_i  (quo[0]),
        .mb_i  (den[0]),
        .sgn_i (pl[0].op == OP_SMUL),
        .neg_i (pl[0].neg_q),
        .res_o (mul_res),
        .err_o (mul_err)
    );

    for (genvar k = 1; k <= DATA_WIDTH; k++) begin : g_div
        if (k == MUL_MERGE) begin : g_merge
            always_comb begin
                pl_in[k] = pl[k-1];
                if ((pl[k-1].op == OP_MUL) || (pl[k-1].op == OP_SMUL)) begin
                    pl_in[k].res = mul_res;
                    pl_in[k].err = mul_err;
                end
            end
        end else begin : g_pass
            assign pl_in[k] = pl[k-1];
        end

        oca_div_step u_step (
            .aclk  (aclk),
            .en    (en[k]),
            .rem_i (rem[k-1]),
            .quo_i (quo[k-1]),
            .den_i (den[k-1]),
            .pl_i  (pl_in[k]),
            .rem_o (rem[k]),
            .quo_o (quo[k]),
            .den_o (den[k]),
            .pl_o  (pl[k])
        );
    end

    always_comb begin
        case (pl[DATA_WIDTH].op)
            OP_DIV, OP_SDIV: val = apply_sign(quo[DATA_WIDTH], pl[DATA_WIDTH].neg_q);
            OP_REM, OP_SREM: val = apply_sign(rem[DATA_WIDTH], pl[DATA_WIDTH].neg_r);
            default:         val = pl[DATA_WIDTH].res;
        endcase
        flag_next = pl[DATA_WIDTH].err;
        data_next = flag_next ? '0 : val;
    end

    always_ff @(posedge aclk) begin
        if (en[DEPTH-1]) begin
            data_reg <= data_next;
            flag_reg <= flag_next;
        end
    end

    assign s_tready = en[0];
    assign m_tvalid = valid_reg[DEPTH-1];
    assign m_tdata  = {{(OUT_TDATA_W-DATA_WIDTH-1){1'b0}}, flag_reg, data_reg};

    a_flag_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tdata[DATA_WIDTH] |-> (m_tdata[DATA_WIDTH-1:0] == '0))
        else $error("flagged result is not zero");

    a_ready_only_stalled: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> m_tvalid && !m_tready)
        else $error("input stalled without a stalled output");

    a_stall_holds_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |=> valid_reg[0])
        else $error("front stage lost a word while stalled");

endmodule

// File: tb/sv/tb.sv
// Self-checking testbench for overflow_checked_alu: drives operation words on the
// input stream and checks every result word against a built-in ALU predictor.
// Depends on oca_pkg and the RTL of overflow_checked_alu.
module tb;
    import oca_pkg::*;

    typedef struct packed {
        logic [3:0] op;
        word_t      a;
        word_t      b;
    } alu_req_t;

    typedef struct packed {
        logic  flag;
        word_t value;
    } alu_res_t;

    logic                   aclk;
    logic                   aresetn;
    logic                   s_tvalid;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata;
    logic                   m_tvalid;
    logic                   m_tready;
    logic [OUT_TDATA_W-1:0] m_tdata;

    alu_req_t pending_ops[$];
    alu_res_t expected_results[$];
    int       mismatches;
    int       cycle_count;
    int       hold_off;
    bit       in_accepted;

    overflow_checked_alu u_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata)
    );

    always begin
        aclk = 1'b0;
        #5;
        aclk = 1'b1;
        #5;
    end

    function automatic word_t mag_of(word_t v);
        return v[DATA_WIDTH-1] ? word_t'(word_t'(0) - v) : v;
    endfunction

    function automatic word_t signed_of(word_t m, bit neg);
        return neg ? word_t'(word_t'(0) - m) : m;
    endfunction

    function automatic alu_res_t alu_predict(alu_req_t r);
        alu_res_t res;
        word_t    a;
        word_t    b;
        word_t    t;
        word_t    ua;
        word_t    ub;
        word_t    lim;
        bit       sa;
        bit       sb;
        bit       err;
        a = r.a;
        b = r.b;
        sa = a[DATA_WIDTH-1];
        sb = b[DATA_WIDTH-1];
        err = 1'b0;
        t = '0;
        case (r.op)
            OP_ADD: begin
                err = a > WMASK - b;
                t = a + b;
            end
            OP_SUB: begin
                err = a < b;
                t = a - b;
            end
            OP_MUL: begin
                err = b != 0 && a > WMASK / b;
                t = a * b;
            end
            OP_DIV: begin
                err = b == 0;
                if (!err) t = a / b;
            end
            OP_REM: begin
                err = b == 0;
                if (!err) t = a % b;
            end
            OP_SHL: begin
                err = b >= WIDTH_VAL || a > (WMASK >> b);
                if (!err) t = a << b;
            end
            OP_SHR: begin
                err = b >= WIDTH_VAL;
                if (!err) t = a >> b;
            end
            OP_SADD: begin
                t = a + b;
                err = ((a ^ t) & (b ^ t) & WSIGN) != 0;
            end
            OP_SSUB: begin
                t = a - b;
                err = ((a ^ b) & (a ^ t) & WSIGN) != 0;
            end
            OP_SMUL: begin
                ua = mag_of(a);
                ub = mag_of(b);
                if (ua != 0 && ub != 0) begin
                    lim = (sa != sb) ? WSIGN : SMAX;
                    err = ua > lim / ub;
                    t = signed_of(ua * ub, sa != sb);
                end
            end
            OP_SDIV, OP_SREM: begin
                err = b == 0 || (a == WSIGN && b == WMASK);
                if (!err) begin
                    ua = mag_of(a);
                    ub = mag_of(b);
                    if (r.op == OP_SDIV) t = signed_of(ua / ub, sa != sb);
                    else t = signed_of(ua % ub, sa);
                end
            end
            OP_NEG: begin
                err = a == WSIGN;
                t = word_t'(0) - a;
            end
            OP_SSHL: begin
                err = sa || b >= WIDTH_VAL || a > (SMAX >> b);
                if (!err) t = a << b;
            end
            OP_SSHR: begin
                err = sa || b >= WIDTH_VAL;
                if (!err) t = a >> b;
            end
            default: err = 1'b1;
        endcase
        res.flag = err;
        res.value = err ? word_t'(0) : t;
        return res;
    endfunction

    function automatic word_t rand_word();
        word_t w;
        int    k;
        w = {$urandom, $urandom};
        k = $urandom_range(0, 9);
        case (k)
            0: w = w >> $urandom_range(0, 63);
            1: w = '0 | $urandom_range(0, 70);
            2: w = WSIGN;
            3: w = SMAX;
            4: w = WMASK - $urandom_range(0, 3);
            5: w = word_t'(0) - (w >> $urandom_range(1, 63));
            6: w = w >> $urandom_range(32, 63);
            default: ;
        endcase
        return w;
    endfunction

    task automatic add_op(logic [3:0] op, word_t a, word_t b);
        alu_req_t r;
        r.op = op;
        r.a = a;
        r.b = b;
        pending_ops.push_back(r);
    endtask

    // Driver: one word queued at a time, with a random gap between words.
    always @(negedge aclk) begin
        static int gap = 0;
        alu_req_t  r;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else if (s_tvalid && !in_accepted) begin
        end else if (gap > 0) begin
            gap--;
            s_tvalid <= 1'b0;
        end else if (pending_ops.size() > 0) begin
            r = pending_ops.pop_front();
            s_tdata <= IN_TDATA_W'({r.b, r.a, r.op});
            s_tvalid <= 1'b1;
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(0, 9);
            if ($urandom_range(0, 1)) gap = 0;
        end else begin
            s_tvalid <= 1'b0;
        end
    end

    // The accepted word is predicted at the edge where it is taken.
    always @(posedge aclk) begin
        alu_req_t r;
        in_accepted = aresetn && s_tvalid && s_tready;
        if (in_accepted) begin
            r.op = s_tdata[3:0];
            r.a = s_tdata[67:4];
            r.b = s_tdata[131:68];
            expected_results.push_back(alu_predict(r));
        end
    end

    always @(negedge aclk) begin
        static int stall = 0;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else if (hold_off > 0) begin
            hold_off--;
            m_tready <= 1'b0;
        end else if (stall > 0) begin
            stall--;
            m_tready <= 1'b0;
        end else begin
            m_tready <= 1'b1;
            if ($urandom_range(0, 1)) stall = $urandom_range(0, 9);
        end
    end

    // Monitor.
    always @(posedge aclk) begin
        alu_res_t got;
        alu_res_t exp_res;
        if (aresetn && m_tvalid && m_tready) begin
            got.value = m_tdata[63:0];
            got.flag = m_tdata[64];
            if (expected_results.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("Unexpected result word %h", got);
            end else begin
                exp_res = expected_results.pop_front();
                if (got.value !== exp_res.value || got.flag !== exp_res.flag) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("Mismatch: expected value %h flag %b, got value %h flag %b",
                                 exp_res.value, exp_res.flag, got.value, got.flag);
                end
            end
        end
    end

    always @(posedge aclk) begin
        cycle_count++;
        if (cycle_count > 400000) begin
            $display("FAIL");
            $finish;
        end
    end

    initial begin
        aresetn = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        m_tready = 1'b0;
        mismatches = 0;
        cycle_count = 0;
        hold_off = 0;
        repeat (9) @(posedge aclk);
        aresetn <= 1'b1;

        add_op(OP_ADD, WMASK, 64'd1);
        add_op(OP_ADD, WMASK - 1, 64'd1);
        add_op(OP_SUB, 64'd0, 64'd1);
        add_op(OP_MUL, WMASK, 64'd0);
        add_op(OP_MUL, 64'h1_0000_0000, 64'h1_0000_0000);
        add_op(OP_DIV, 64'd5, 64'd0);
        add_op(OP_REM, WMASK, 64'd7);
        add_op(OP_SHL, 64'd1, 64'd63);
        add_op(OP_SHL, 64'd1, 64'd64);
        add_op(OP_SHR, WMASK, 64'd63);
        add_op(OP_SADD, SMAX, 64'd1);
        add_op(OP_SSUB, WSIGN, 64'd1);
        add_op(OP_SSUB, 64'd0, WSIGN);
        add_op(OP_SMUL, WSIGN, 64'd1);
        add_op(OP_SMUL, WSIGN, WMASK);
        add_op(OP_SMUL, 64'h4000_0000_0000_0000, word_t'(-2));
        add_op(OP_SDIV, WSIGN, WMASK);
        add_op(OP_SDIV, word_t'(-7), 64'd2);
        add_op(OP_SREM, word_t'(-7), 64'd2);
        add_op(OP_SREM, 64'd7, 64'd0);
        add_op(OP_NEG, WSIGN, WMASK);
        add_op(OP_SSHL, 64'd1, 64'd62);
        add_op(OP_SSHL, word_t'(-1), 64'd1);
        add_op(OP_SSHR, 64'd8, WMASK);
        add_op(4'd15, WMASK, WMASK);

        for (int i = 0; i < 1675; i++) begin
            if (i == 600) begin
                wait (pending_ops.size() == 0);
                hold_off = 300;
                for (int j = 0; j < 150; j++)
                    add_op(4'($urandom_range(0, 15)), rand_word(), rand_word());
            end
            add_op(4'($urandom_range(0, 15)), rand_word(), rand_word());
        end

        wait (pending_ops.size() == 0);
        @(posedge aclk);
        while (s_tvalid) @(posedge aclk);
        wait (expected_results.size() == 0);
        repeat (80) @(posedge aclk);
        if (mismatches == 0 && expected_results.size() == 0) begin
            $display("PASS");
        end else begin
            $display("FAIL");
        end
        $finish;
    end
endmodule

// File: filelist.f
rtl/oca_pkg.sv
rtl/oca_decode.sv
rtl/oca_mul.sv
rtl/oca_div_step.sv
rtl/overflow_checked_alu.sv
tb/sv/tb.sv
